>>> rtl/core/okl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_pkg
// Shared types and sizes for the ordered key list and its cell chain.
// ----------------------------------------------------------------------------
package okl_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // search transaction travelling down the chain
    typedef struct packed {
        logic                act;
        logic [1:0]          op;
        logic [KEY_BITS-1:0] key;
        logic                hit;
        logic [KEY_BITS-1:0] mkey;
    } t_wave;

    // append write, broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [KEY_BITS-1:0] key;
    } t_wr;

endpackage

>>> rtl/core/ordered_key_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_list
// Fixed-capacity ordered key list with append, delete-first-match and
// membership query, built as a chain of key cells.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start & !busy        i_req_type, i_item_key
//  result    o_valid (1 cycle)    o_match_key, o_found, o_overflow, o_live_count
//
//  Insert and unused request types: result in the cycle after acceptance.
//  Delete and query: a search transaction walks the cell chain one cell per
//  cycle; the result is registered when the transaction leaves the last cell,
//  and busy stays high until then.
//  Synchronous active-low reset empties the list.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module ordered_key_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_item_key,
    output logic        o_valid,
    output logic [31:0] o_match_key,
    output logic        o_found,
    output logic        o_overflow,
    output logic [6:0]  o_live_count
);
    import okl_pkg::*;

    logic                r_busy;
    t_wave               r_launch;
    logic [CNT_W-1:0]    r_count;
    logic                r_valid;
    logic [KEY_BITS-1:0] r_match;
    logic                r_found;
    logic                r_ovf;

    t_wave               wave [CAPACITY+1];
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic                cell_pull [CAPACITY];
    logic [KEY_BITS-1:0] right_key [CAPACITY];
    logic                right_pull [CAPACITY];

    logic                accept;
    logic                full;
    logic [KEY_BITS-1:0] in_key;
    t_wr                 wr;
    t_wave               fin;

    assign accept = start && !r_busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign in_key = KEY_BITS'(i_item_key);
    assign wr.en  = accept && (i_req_type == OP_INSERT) && !full;
    assign wr.key = in_key;
    assign wave[0] = r_launch;
    assign fin    = wave[CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == CAPACITY - 1) begin : g_last
                assign right_key[g]  = '0;
                assign right_pull[g] = 1'b0;
            end else begin : g_mid
                assign right_key[g]  = cell_key[g+1];
                assign right_pull[g] = cell_pull[g+1];
            end

            okl_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_idx       (IDX_W'(g)),
                .i_count     (r_count),
                .i_wr        (wr),
                .i_wave      (wave[g]),
                .o_wave      (wave[g+1]),
                .i_right_key (right_key[g]),
                .i_right_pull(right_pull[g]),
                .o_key       (cell_key[g]),
                .o_pull      (cell_pull[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_launch <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_match  <= '0;
            r_found  <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_valid      <= 1'b0;
            r_launch.act <= 1'b0;
            if (accept) begin
                unique case (i_req_type) inside
                    OP_INSERT: begin
                        r_valid <= 1'b1;
                        r_match <= '0;
                        r_found <= 1'b0;
                        r_ovf   <= full;
                        if (!full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    OP_DELETE, OP_QUERY: begin
                        r_busy        <= 1'b1;
                        r_launch.act  <= 1'b1;
                        r_launch.op   <= i_req_type;
                        r_launch.key  <= in_key;
                        r_launch.hit  <= 1'b0;
                        r_launch.mkey <= '0;
                    end
                    default: begin
                        r_valid <= 1'b1;
                        r_match <= '0;
                        r_found <= 1'b0;
                        r_ovf   <= 1'b0;
                    end
                endcase
            end else if (fin.act) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
                r_found <= fin.hit;
                r_ovf   <= 1'b0;
                r_match <= (fin.op == OP_QUERY && fin.hit) ? fin.mkey : '0;
                if (fin.op == OP_DELETE && fin.hit) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    assign busy         = r_busy;
    assign o_valid      = r_valid;
    assign o_match_key  = 32'(r_match);
    assign o_found      = r_found;
    assign o_overflow   = r_ovf;
    assign o_live_count = 7'(r_count);

endmodule

>>> rtl/core/okl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_cell
// One list slot: holds a key, compares it against the passing search
// transaction and pulls its right neighbor's key when a delete closes a gap.
// ----------------------------------------------------------------------------
module okl_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [okl_pkg::IDX_W-1:0]    i_idx,
    input  logic [okl_pkg::CNT_W-1:0]    i_count,
    input  okl_pkg::t_wr                 i_wr,
    input  okl_pkg::t_wave               i_wave,
    output okl_pkg::t_wave               o_wave,
    input  logic [okl_pkg::KEY_BITS-1:0] i_right_key,
    input  logic                         i_right_pull,
    output logic [okl_pkg::KEY_BITS-1:0] o_key,
    output logic                         o_pull
);
    import okl_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    t_wave               r_wave;
    t_wave               n_wave;
    logic                live;
    logic                eq;

    always_comb begin
        live   = CNT_W'(i_idx) < i_count;
        eq     = live && (r_key == i_wave.key);
        n_wave = i_wave;
        if (i_wave.act && !i_wave.hit && eq) begin
            n_wave.hit  = 1'b1;
            n_wave.mkey = r_key;
        end
        // entries after the removed one move down one place
        o_pull = i_wave.act && live && i_wave.hit && (i_wave.op == OP_DELETE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (CNT_W'(i_idx) == i_count)) begin
            r_key <= i_wr.key;
        end else if (i_right_pull) begin
            r_key <= i_right_key;
        end
    end

    assign o_wave = r_wave;
    assign o_key  = r_key;

endmodule
